// File: rtl/core/spmf_pkg.sv
// Shared types, constants and codes of the strict-priority multi-FIFO.
// No dependencies; imported by every module under rtl/core except spmf_ram.
package spmf_pkg;

    localparam int LEVELS      = 8;
    localparam int LVL_W       = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int MSG_WIDTH   = 32;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_D = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = (STORE_D > 1) ? $clog2(STORE_D) : 1;

    // command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = 2;
    localparam int CQ_CNT_W = 3;

    localparam logic       CMD_PUT  = 1'b0;
    localparam logic       CMD_GET  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                 is_get;
        logic [LVL_W-1:0]     prio;
        logic [MSG_WIDTH-1:0] msg;
    } t_cmd;

endpackage

// File: rtl/core/spmf_ram.sv
// Generic single-port RAM, registered read, read data held between reads.
// No dependencies.
module spmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/spmf_front.sv
// Front end: input register that takes transactions and decodes them into commands.
// Depends on spmf_pkg.
module spmf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_command,
    input  logic [31:0]                    i_message_in,
    input  logic [spmf_pkg::LVL_W-1:0]     i_priority_in,
    output logic                           o_push,
    output spmf_pkg::t_cmd                 o_cmd,
    input  logic                           i_q_full
);
    import spmf_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_cmd.is_get = (i_command == CMD_GET);
        n_cmd.prio   = i_priority_in;
        // store only MSG_WIDTH bits of the word
        n_cmd.msg    = MSG_WIDTH'(i_message_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

endmodule

// File: rtl/core/spmf_cmdq.sv
// Short command queue decoupling the front end from the back end.
// Depends on spmf_pkg.
module spmf_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spmf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spmf_pkg::t_cmd o_cmd
);
    import spmf_pkg::*;

    t_cmd                r_ent [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr;
    logic [CQ_PTR_W-1:0] r_rd;
    logic [CQ_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/spmf_back.sv
// Back end: per-level FIFO bookkeeping, priority encoder, message store access
// and output register. Depends on spmf_pkg and spmf_ram.
module spmf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  spmf_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [31:0]                o_message_out,
    output logic [spmf_pkg::LVL_W-1:0] o_priority_out
);
    import spmf_pkg::*;

    // per-level bookkeeping
    logic [PTR_W-1:0]  r_head [LEVELS];
    logic [PTR_W-1:0]  r_tail [LEVELS];
    logic [CNT_W-1:0]  r_cnt  [LEVELS];
    logic [LEVELS-1:0] r_mask;

    // access stage (RAM read in flight)
    logic             r_d_valid;
    logic [1:0]       r_d_status;
    logic [LVL_W-1:0] r_d_prio;
    logic             r_d_rd;

    // output register
    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [31:0]      r_o_msg;
    logic [LVL_W-1:0] r_o_prio;

    logic                 d_move;
    logic                 e_fire;
    logic [LVL_W-1:0]     enc;
    logic                 all_empty;
    logic [LVL_W-1:0]     idx;
    logic [PTR_W-1:0]     slot;
    logic [PTR_W-1:0]     n_slot;
    logic [CNT_W-1:0]     cnt;
    logic                 full;
    logic                 do_put;
    logic                 do_get;
    logic [ADDR_W-1:0]    addr;
    logic [MSG_WIDTH-1:0] rdata;
    logic [1:0]           n_status;

    // highest set bit of the non-empty mask
    always_comb begin
        enc = '0;
        for (int p = 0; p < LEVELS; p++) begin
            if (r_mask[p]) begin
                enc = LVL_W'(p);
            end
        end
    end

    assign all_empty = (r_mask == '0);
    assign d_move    = r_d_valid && (!r_o_valid || i_ready);
    assign e_fire    = i_cmd_valid && (!r_d_valid || d_move);
    assign o_pop     = e_fire;

    assign idx    = i_cmd.is_get ? enc : i_cmd.prio;
    assign cnt    = r_cnt[idx];
    assign slot   = i_cmd.is_get ? r_head[idx] : r_tail[idx];
    assign n_slot = (slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    assign full   = (cnt == CNT_W'(QUEUE_DEPTH));
    assign do_put = e_fire && !i_cmd.is_get && !full;
    assign do_get = e_fire && i_cmd.is_get && !all_empty;
    assign addr   = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

    always_comb begin
        n_status = ST_OK;
        if (i_cmd.is_get && all_empty) begin
            n_status = ST_EMPTY;
        end else if (!i_cmd.is_get && full) begin
            n_status = ST_FULL;
        end
    end

    spmf_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_put),
        .i_re    (do_get),
        .i_addr  (addr),
        .i_wdata (i_cmd.msg),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_mask <= '0;
        end else if (do_put) begin
            r_tail[idx]  <= n_slot;
            r_cnt[idx]   <= cnt + 1'b1;
            r_mask[idx]  <= 1'b1;
        end else if (do_get) begin
            r_head[idx] <= n_slot;
            r_cnt[idx]  <= cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
                r_mask[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (e_fire) begin
                r_d_valid <= 1'b1;
            end else if (d_move) begin
                r_d_valid <= 1'b0;
            end
            if (d_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_fire) begin
            r_d_status <= n_status;
            r_d_prio   <= do_get ? idx : '0;
            r_d_rd     <= do_get;
        end
        if (d_move) begin
            r_o_status <= r_d_status;
            r_o_prio   <= r_d_prio;
            r_o_msg    <= r_d_rd ? 32'(rdata) : 32'd0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_message_out  = r_o_msg;
    assign o_priority_out = r_o_prio;

endmodule

// File: rtl/core/strict_priority_multi_fifo_unit.sv
// Top level of the strict-priority multi-FIFO: front end, command queue, back end.
// Depends on spmf_pkg, spmf_front, spmf_cmdq, spmf_back (and spmf_ram below it).
//
// Usage
//   Input channel (i_valid / o_ready) carries one command per transaction:
//     i_command 0 = put i_message_in on level i_priority_in, 1 = get the oldest
//     message of the highest non-empty level (7 highest).
//   Output channel (o_valid / i_ready) returns exactly one result per command,
//     in command order: o_status (0 ok, 1 level full on put, 2 all empty on
//     get), o_message_out and o_priority_out (nonzero only for a good get).
//   Path: a taken command passes the input register, the command queue, the
//     store access stage and the output register before its result shows on o_valid.
//   Throughput: one command per cycle sustained while i_ready stays high; the single-port message store
//     does one access per command, and all FIFO pointers live in flops.
//   Reset (i_rst_n low, synchronous): all levels empty, pointers and counts
//     zero, no result pending. The message store needs no clearing since only
//     written slots are ever read.
//   Receiver stall: the output register holds its result; the access stage and
//     the four-entry command queue keep filling, then o_ready drops until the
//     receiver takes results again. Nothing is dropped or repeated.
module strict_priority_multi_fifo_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_command,
    input  logic [31:0]                    i_message_in,
    input  logic [spmf_pkg::LVL_W-1:0]     i_priority_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_message_out,
    output logic [spmf_pkg::LVL_W-1:0]     o_priority_out
);
    import spmf_pkg::*;

    // front -> queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue -> back
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    spmf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_message_in  (i_message_in),
        .i_priority_in (i_priority_in),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_q_full      (q_full)
    );

    spmf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back end pops a command only when its result has somewhere to go
    spmf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_message_out  (o_message_out),
        .o_priority_out (o_priority_out)
    );

endmodule
